### hw/rtl/sheq_pkg.sv
`default_nettype none
package sheq_pkg;

  localparam int HW = 30;
  localparam int POS_W = 19;
  localparam int SPAN_W = 20;
  localparam int END_W = 21;
  localparam int CMP_W = 22;
  localparam int DEF_MAX_LEN = 524288;
  localparam logic [HW-1:0] HASH_MOD = 30'd1000000009;
  localparam logic [HW-1:0] HASH_BASE = 30'd31;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_RSVD   = 2'd3
  } act_t;

  typedef struct packed {
    act_t              kind;
    logic [7:0]        ch;
    logic [POS_W-1:0]  a;
    logic [POS_W-1:0]  b;
    logic [POS_W-1:0]  d;
    logic [END_W-1:0]  a_end;
    logic [END_W-1:0]  b_end;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AP_START,
    S_AP_WAIT1,
    S_AP_WAIT2,
    S_Q_CHECK,
    S_Q_RD1,
    S_Q_RD2,
    S_Q_RD3,
    S_Q_RD4,
    S_Q_RD5,
    S_Q_MUL,
    S_Q_WAIT,
    S_Q_OUT
  } state_t;

  // (e - s) mod p for e, s already reduced
  function automatic logic [HW-1:0] mod_sub(input logic [HW-1:0] e, input logic [HW-1:0] s);
    logic [HW:0] t;
    t = {1'b0, e} - {1'b0, s};
    if (e < s) t = t + {1'b0, HASH_MOD};
    return t[HW-1:0];
  endfunction

  function automatic logic [HW-1:0] mod_add(input logic [HW-1:0] x, input logic [HW-1:0] y);
    logic [HW:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, HASH_MOD}) t = t - {1'b0, HASH_MOD};
    return t[HW-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/substring_hash_equality_top.sv
// substring equality by polynomial rolling hash, base 31, modulus 1000000009
// input channel in_valid/in_ready carries one beat per item: action 0 appends
// char_code, action 1 queries first_pos/second_pos/span_len, action 2 clears;
// action 3 is dropped. output channel out_valid/out_ready carries one beat per
// query with is_equal and out_of_range; appends and clears give no beat.
// items pass a one-entry front register and a two-entry queue, so the input
// keeps accepting while the back end works or a result waits to be taken.
// the back end runs one item at a time on a bit-serial modular multiplier:
// an append takes two products, a query five prefix/power memory reads plus
// one product, an out-of-range query skips the reads and the product, and a
// clear is done in the idle state. throughput is set by the multiplier and
// the single read port of each memory.
// when out_ready is low the finished result holds in the output register; the
// back end stalls at its next result and the queue then fills and drops in_ready.
// reset empties the string and the queue; no clearing pass is needed.
`default_nettype none
module substring_hash_equality_top
  import sheq_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [7:0]        char_code,
  input  wire logic [POS_W-1:0]  first_pos,
  input  wire logic [POS_W-1:0]  second_pos,
  input  wire logic [SPAN_W-1:0] span_len,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   is_equal,
  output logic                   out_of_range
);

  logic f_valid, f_ready, q_valid, q_ready;
  entry_t f_ent, q_ent;

  sheq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .char_code  (char_code),
    .first_pos  (first_pos),
    .second_pos (second_pos),
    .span_len   (span_len),
    .f_valid    (f_valid),
    .f_ready    (f_ready),
    .f_ent      (f_ent)
  );

  sheq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_ent    (f_ent),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_ent   (q_ent)
  );

  sheq_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_ent        (q_ent),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_equal     (is_equal),
    .out_of_range (out_of_range)
  );

endmodule
`default_nettype wire

### hw/rtl/sheq_front.sv
`default_nettype none
module sheq_front
  import sheq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [7:0]        char_code,
  input  wire logic [POS_W-1:0]  first_pos,
  input  wire logic [POS_W-1:0]  second_pos,
  input  wire logic [SPAN_W-1:0] span_len,
  output logic                   f_valid,
  input  wire logic              f_ready,
  output entry_t                 f_ent
);

  entry_t ent_next;
  logic act_ok;
  logic [POS_W-1:0] lo, hi;

  always_comb begin
    act_ok = 1'b1;
    ent_next.kind = ACT_APPEND;
    unique case (action)
      ACT_APPEND: ent_next.kind = ACT_APPEND;
      ACT_QUERY: ent_next.kind = ACT_QUERY;
      ACT_CLEAR: ent_next.kind = ACT_CLEAR;
      default: act_ok = 1'b0;
    endcase
    // order the two starts so that lo <= hi
    if (first_pos > second_pos) begin
      lo = second_pos;
      hi = first_pos;
    end else begin
      lo = first_pos;
      hi = second_pos;
    end
    ent_next.ch = char_code;
    ent_next.a = lo;
    ent_next.b = hi;
    ent_next.d = hi - lo;
    ent_next.a_end = {2'b00, lo} + {1'b0, span_len};
    ent_next.b_end = {2'b00, hi} + {1'b0, span_len};
  end

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      if (f_valid && f_ready) f_valid <= 1'b0;
      if (in_valid && in_ready && act_ok) f_valid <= 1'b1;
    end
    if (in_valid && in_ready) f_ent <= ent_next;
  end

endmodule
`default_nettype wire

### hw/rtl/sheq_queue.sv
`default_nettype none
module sheq_queue
  import sheq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire entry_t in_ent,
  output logic        out_valid,
  input  wire logic   out_ready,
  output entry_t      out_ent
);

  entry_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_ent = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slots[wr_ptr] <= in_ent;
  end

endmodule
`default_nettype wire

### hw/rtl/sheq_modmul.sv
`default_nettype none
module sheq_modmul
  import sheq_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [HW-1:0] x,
  input  wire logic [HW-1:0] y,
  output logic               done,
  output logic [HW-1:0]      prod
);

  localparam int CNT_W = $clog2(HW);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [HW-1:0] xs, ys;
  logic [HW+1:0] t;

  // one bit of x per cycle, msb first: acc = 2*acc + bit*y mod p
  always_comb begin
    t = {1'b0, prod, 1'b0};
    if (t >= {2'b00, HASH_MOD}) t = t - {2'b00, HASH_MOD};
    if (xs[HW-1]) t = t + {2'b00, ys};
    if (t >= {2'b00, HASH_MOD}) t = t - {2'b00, HASH_MOD};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(HW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      prod <= '0;
      xs <= x;
      ys <= y;
    end else if (busy) begin
      prod <= t[HW-1:0];
      xs <= {xs[HW-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sheq_back.sv
`default_nettype none
module sheq_back
  import sheq_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  wire entry_t q_ent,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        is_equal,
  output logic        out_of_range
);

  localparam int AW = $clog2(MAX_LEN + 1);

  state_t state, state_next;
  entry_t cur;
  logic [AW-1:0] loaded;
  logic [HW-1:0] pow;

  logic [HW-1:0] ph_mem [MAX_LEN + 1];
  logic [HW-1:0] pw_mem [MAX_LEN + 1];
  logic [HW-1:0] ph_rdata, pw_rdata, ph_val, pw_val;
  logic ph_rd_zero, pw_rd_zero;
  logic [AW-1:0] ph_raddr, pw_raddr, ph_waddr;
  logic [HW-1:0] ph_wdata;
  logic ph_we, pw_we;

  logic mul_start, mul_done;
  logic [HW-1:0] mul_x, mul_y, mul_prod;

  logic [HW-1:0] h_prev, hb_end, hb_start, ha_end, ha_start, pwd;
  logic res_eq, res_oor, out_load, oor;
  logic [AW-1:0] loaded_inc;

  function automatic logic [AW-1:0] to_addr(input logic [END_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return w[AW-1:0];
  endfunction

  assign loaded_inc = loaded + AW'(1);
  assign ph_val = ph_rd_zero ? '0 : ph_rdata;
  assign pw_val = pw_rd_zero ? HW'(1) : pw_rdata;
  assign oor = CMP_W'(cur.b_end) > CMP_W'(loaded);
  assign out_load = (state == S_Q_OUT) && (!out_valid || out_ready);

  sheq_modmul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    ph_raddr = '0;
    pw_raddr = '0;
    ph_we = 1'b0;
    ph_waddr = loaded_inc;
    ph_wdata = mod_add(h_prev, mul_prod);
    pw_we = 1'b0;
    mul_start = 1'b0;
    mul_x = HW'(cur.ch);
    mul_y = pow;
    unique case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        // last prefix word is ready by the time an append starts
        ph_raddr = loaded;
        if (q_valid) begin
          unique case (q_ent.kind)
            ACT_APPEND: if (loaded != AW'(MAX_LEN)) state_next = S_AP_START;
            ACT_QUERY: state_next = S_Q_CHECK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_AP_START: begin
        ph_raddr = loaded;
        mul_start = 1'b1;
        state_next = S_AP_WAIT1;
      end
      S_AP_WAIT1: begin
        if (mul_done) begin
          ph_we = 1'b1;
          mul_start = 1'b1;
          mul_x = pow;
          mul_y = HASH_BASE;
          state_next = S_AP_WAIT2;
        end
      end
      S_AP_WAIT2: begin
        if (mul_done) begin
          pw_we = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_Q_CHECK: begin
        ph_raddr = to_addr(cur.b_end);
        state_next = oor ? S_Q_OUT : S_Q_RD1;
      end
      S_Q_RD1: begin
        ph_raddr = to_addr(END_W'(cur.b));
        state_next = S_Q_RD2;
      end
      S_Q_RD2: begin
        ph_raddr = to_addr(cur.a_end);
        state_next = S_Q_RD3;
      end
      S_Q_RD3: begin
        ph_raddr = to_addr(END_W'(cur.a));
        pw_raddr = to_addr(END_W'(cur.d));
        state_next = S_Q_RD4;
      end
      S_Q_RD4: state_next = S_Q_RD5;
      S_Q_RD5: state_next = S_Q_MUL;
      S_Q_MUL: begin
        // compare hb with ha * base^gap, same test as scaling hb by the inverse
        mul_start = 1'b1;
        mul_x = mod_sub(ha_end, ha_start);
        mul_y = pwd;
        state_next = S_Q_WAIT;
      end
      S_Q_WAIT: if (mul_done) state_next = S_Q_OUT;
      S_Q_OUT: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[ph_waddr] <= ph_wdata;
    if (pw_we) pw_mem[loaded_inc] <= mul_prod;
    ph_rdata <= ph_mem[ph_raddr];
    pw_rdata <= pw_mem[pw_raddr];
    ph_rd_zero <= (ph_raddr == '0);
    pw_rd_zero <= (pw_raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      pow <= HW'(1);
      out_valid <= 1'b0;
    end else begin
      if (state == S_IDLE && q_valid && q_ent.kind == ACT_CLEAR) begin
        loaded <= '0;
        pow <= HW'(1);
      end
      if (state == S_AP_WAIT2 && mul_done) begin
        loaded <= loaded_inc;
        pow <= mul_prod;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
    end
    if (state == S_IDLE && q_valid) cur <= q_ent;
    if (state == S_AP_START) h_prev <= ph_val;
    if (state == S_Q_CHECK) begin
      res_oor <= oor;
      res_eq <= 1'b0;
    end
    if (state == S_Q_RD1) hb_end <= ph_val;
    if (state == S_Q_RD2) hb_start <= ph_val;
    if (state == S_Q_RD3) ha_end <= ph_val;
    if (state == S_Q_RD4) begin
      ha_start <= ph_val;
      pwd <= pw_val;
    end
    if (state == S_Q_WAIT && mul_done) res_eq <= (mul_prod == mod_sub(hb_end, hb_start));
    if (out_load) begin
      is_equal <= res_eq;
      out_of_range <= res_oor;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= AW'(MAX_LEN)) else $error("loaded length past capacity");
  a_no_zero_write: assert property (@(posedge clk) disable iff (rst)
    ph_we |-> ph_waddr != '0) else $error("prefix entry zero overwritten");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_load && res_oor |-> !res_eq) else $error("equal flag on out-of-range query");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (q_ready && q_valid) |=> state != S_IDLE || $past(q_ent.kind) != ACT_QUERY)
    else $error("query popped without being started");

endmodule
`default_nettype wire

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sheq_pkg::*;

  localparam longint unsigned PRIME = 64'd1000000009;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_APPEND;
  logic [7:0] char_code = '0;
  logic [POS_W-1:0] first_pos = '0;
  logic [POS_W-1:0] second_pos = '0;
  logic [SPAN_W-1:0] span_len = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_equal;
  logic out_of_range;

  int unsigned cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  substring_hash_equality_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .char_code(char_code), .first_pos(first_pos),
    .second_pos(second_pos), .span_len(span_len), .out_valid(out_valid),
    .out_ready(out_ready), .is_equal(is_equal), .out_of_range(out_of_range)
  );

  class hash_scoreboard;
    longint unsigned prefix[$];
    longint unsigned pow31[$];
    longint unsigned inv31;
    bit [1:0] pending[$];
    int errors;
    int results;
    int queries;
    int oor_seen;
    int eq_seen;

    function new();
      longint unsigned acc;
      longint unsigned b;
      longint unsigned e;
      acc = 1;
      b = 31;
      e = PRIME - 2;
      while (e != 0) begin
        if (e[0]) acc = (acc * b) % PRIME;
        b = (b * b) % PRIME;
        e = e >> 1;
      end
      inv31 = acc;
      prefix.push_back(0);
      pow31.push_back(1);
      errors = 0;
      results = 0;
      queries = 0;
      oor_seen = 0;
      eq_seen = 0;
    endfunction

    function longint unsigned inv_pow(int unsigned n);
      longint unsigned acc;
      longint unsigned b;
      acc = 1;
      b = inv31;
      while (n != 0) begin
        if (n[0]) acc = (acc * b) % PRIME;
        b = (b * b) % PRIME;
        n = n >> 1;
      end
      return acc;
    endfunction

    function longint unsigned span_hash(int unsigned s, int unsigned n);
      return (prefix[s + n] + PRIME - prefix[s]) % PRIME;
    endfunction

    function void note_beat(logic [1:0] act, logic [7:0] ch, int unsigned pa,
                            int unsigned pb, int unsigned n);
      int unsigned lo;
      int unsigned hi;
      int unsigned len;
      longint unsigned later;
      len = prefix.size() - 1;
      if (act == ACT_APPEND) begin
        if (len < DEF_MAX_LEN) begin
          if (pow31.size() <= len) pow31.push_back((pow31[len - 1] * 31) % PRIME);
          prefix.push_back((prefix[len] + (longint'(ch) * pow31[len]) % PRIME) % PRIME);
        end
      end else if (act == ACT_CLEAR) begin
        prefix.delete();
        prefix.push_back(0);
      end else if (act == ACT_QUERY) begin
        queries++;
        lo = (pa < pb) ? pa : pb;
        hi = (pa < pb) ? pb : pa;
        if (longint'(hi) + n > len) pending.push_back(2'b01);
        else begin
          later = (inv_pow(hi - lo) * span_hash(hi, n)) % PRIME;
          pending.push_back({later == span_hash(lo, n), 1'b0});
        end
      end
    endfunction

    function void check_beat(logic eq, logic oor);
      bit [1:0] exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing expected: is_equal=%0b out_of_range=%0b", eq, oor);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      results++;
      if (oor) oor_seen++;
      if (eq) eq_seen++;
      if (eq !== exp_r[1]) begin
        $error("is_equal expected %0b actual %0b", exp_r[1], eq);
        errors++;
      end
      if (oor !== exp_r[0]) begin
        $error("out_of_range expected %0b actual %0b", exp_r[0], oor);
        errors++;
      end
    endfunction

    function int unsigned loaded();
      return prefix.size() - 1;
    endfunction
  endclass

  hash_scoreboard sb = new();

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (cycles % 500 < 120) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) sb.check_beat(is_equal, out_of_range);
    if (!rst && in_valid && in_ready)
      sb.note_beat(action, char_code, first_pos, second_pos, span_len);
    if (cycles > LIMIT) begin
      $display("FAIL substring_hash_equality_top");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] act, logic [7:0] ch, int unsigned pa,
                           int unsigned pb, int unsigned n);
    in_valid <= 1'b1;
    action <= act;
    char_code <= ch;
    first_pos <= pa[POS_W-1:0];
    second_pos <= pb[POS_W-1:0];
    span_len <= n[SPAN_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_query();
    int unsigned len;
    int unsigned n;
    int unsigned pa;
    int unsigned pb;
    len = sb.loaded();
    case ($urandom_range(0, 9))
      0: send_beat(ACT_QUERY, 0, $urandom, $urandom, $urandom);
      1: send_beat(ACT_QUERY, 0, $urandom_range(0, len + 2), $urandom_range(0, len + 2),
                   $urandom_range(0, 3));
      default: begin
        n = $urandom_range(0, len);
        pa = $urandom_range(0, len - n);
        pb = $urandom_range(0, len - n);
        send_beat(ACT_QUERY, 0, pa, pb, n);
      end
    endcase
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned per;
    int unsigned i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty string, extremes, repeats, high bytes, clear, action 3
    send_beat(ACT_QUERY, 0, 0, 0, 0);
    send_beat(ACT_QUERY, 0, 19'h7FFFF, 19'h7FFFF, 20'hFFFFF);
    send_beat(ACT_QUERY, 0, 0, 0, 1);
    for (i = 0; i < 6; i++) send_beat(ACT_APPEND, (i % 2) ? 8'hFF : 8'h80, 0, 0, 0);
    send_beat(ACT_QUERY, 0, 0, 2, 4);
    send_beat(ACT_QUERY, 0, 3, 0, 3);
    send_beat(ACT_QUERY, 0, 6, 6, 0);
    send_beat(ACT_QUERY, 0, 7, 0, 0);
    send_beat(ACT_QUERY, 0, 1, 2, 5);
    send_beat(ACT_RSVD, 8'h55, 19'h2AAAA, 19'h55555, 20'hAAAAA);
    send_beat(ACT_APPEND, 8'h00, 0, 0, 0);
    send_beat(ACT_QUERY, 0, 0, 6, 1);
    send_beat(ACT_CLEAR, 0, 0, 0, 0);
    send_beat(ACT_QUERY, 0, 0, 0, 1);
    send_beat(ACT_QUERY, 0, 0, 0, 0);
    go_idle();

    // random: build periodic strings interleaved with queries; occasional clears and noise
    sent = 0;
    while (sent < 800) begin
      burst = $urandom_range(1, 12);
      per = $urandom_range(1, 4);
      for (i = 0; i < burst && sent < 800; i++) begin
        case ($urandom_range(0, 19))
          0: send_beat(ACT_CLEAR, 8'($urandom), $urandom, $urandom, $urandom);
          1: send_beat(ACT_RSVD, 8'($urandom), $urandom, $urandom, $urandom);
          2, 3, 4, 5, 6, 7, 8:
            send_beat(ACT_APPEND,
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(sb.loaded() % per) + 8'hFD,
                      $urandom, $urandom, $urandom);
          default: random_query();
        endcase
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d queries, %0d results (%0d equal, %0d out of range)",
             sb.queries, sb.results, sb.eq_seen, sb.oor_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS substring_hash_equality_top");
    else
      $display("FAIL substring_hash_equality_top");
    $finish;
  end
endmodule

### filelist.f
hw/rtl/sheq_pkg.sv
hw/rtl/sheq_front.sv
hw/rtl/sheq_queue.sv
hw/rtl/sheq_modmul.sv
hw/rtl/sheq_back.sv
hw/rtl/substring_hash_equality_top.sv
sim/tb_top.sv
